// ----- src/assert_macros.svh -----
// Assertion helpers used by the top-level RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every rising clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// The expression must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

// ----- src/i2crb_pkg.sv -----
`timescale 1ns / 1ps

package i2crb_pkg;

   // Event codes carried with each input transaction.
   typedef enum logic [2:0] {
      FUNC_START_WRITE = 3'd0,
      FUNC_START_READ  = 3'd1,
      FUNC_WRITE_BYTE  = 3'd2,
      FUNC_READ_BYTE   = 3'd3,
      FUNC_OTHER       = 3'd4
   } func_type;

   // Configuration register indexes.
   localparam logic [1:0] REG_IDENT_HIGH    = 2'd0;
   localparam logic [1:0] REG_IDENT_LOW     = 2'd1;
   localparam logic [1:0] REG_DISCRIMINATOR = 2'd2;

   localparam logic [15:0] ID_HIGH_ADDR = 16'h3107;
   localparam logic [15:0] ID_LOW_ADDR  = 16'h3108;
   localparam logic [15:0] DISC_ADDR    = 16'h3109;
   localparam logic [7:0]  OUT_OF_WINDOW = 8'hFF;

   localparam logic [1:0] ADDR_BYTES_FULL = 2'd2;

   typedef enum logic [2:0] {
      ST_CLEAR = 3'b001,
      ST_IDLE  = 3'b010,
      ST_EXEC  = 3'b100
   } state_type;

   typedef struct packed {
      logic clr_en;
      logic accept;
      logic load;
   } ctl_cmd_type;

   typedef struct packed {
      logic clr_last;
      logic out_free;
   } dp_status_type;

   // Identification values and per-entry write strobes from the CSR block.
   typedef struct packed {
      logic [2:0] we;
      logic [7:0] ident_high;
      logic [7:0] ident_low;
      logic [7:0] discriminator;
   } id_cfg_type;

endpackage

// ----- src/i2crb_ctrl.sv -----
`timescale 1ns / 1ps

module i2crb_ctrl
   import i2crb_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  dp_status_type status,
   output ctl_cmd_type   cmd
);

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clr_en = 1'b1;
            if (status.clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               state_in   = ST_EXEC;
            end
         end
         ST_EXEC: begin
            // Hold here until the output register can take the result.
            if (status.out_free) begin
               cmd.load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   assign req_tready = (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- src/i2crb_dp.sv -----
`timescale 1ns / 1ps

module i2crb_dp
   import i2crb_pkg::*;
#(
   parameter int WINDOW_BASE = 12288,
   parameter int WINDOW_SIZE = 4096
)
(
   input  logic          clock,
   input  logic          reset,
   input  ctl_cmd_type   cmd,
   output dp_status_type status,
   input  id_cfg_type    id_cfg,
   input  logic [2:0]    req_func,
   input  logic [7:0]    req_byte,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [7:0]    rsp_byte,
   output logic          rsp_flag
);

   localparam int IDX_W = $clog2(WINDOW_SIZE);
   localparam logic [16:0] WIN_LO = 17'(WINDOW_BASE);
   localparam logic [16:0] WIN_HI = 17'(WINDOW_BASE + WINDOW_SIZE);
   localparam logic [15:0] BASE16 = 16'(WINDOW_BASE);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW_SIZE - 1);

   logic [7:0] store_ff [WINDOW_SIZE];
   logic [7:0] rd_data_ff;

   logic [15:0] wr_addr_ff, wr_addr_in;
   logic [15:0] rd_addr_ff, rd_addr_in;
   logic [1:0]  seen_ff, seen_in;
   logic [IDX_W-1:0] clr_idx_ff;
   logic [2:0]  id_ovr_ff, id_ovr_in;

   logic        is_read_ff, rd_win_ff, rd_ovr_ff;
   logic [7:0]  rd_ovr_val_ff;
   logic        rd_ovr;
   logic [7:0]  rd_ovr_val;

   logic        out_valid_ff;
   logic [7:0]  out_byte_ff;
   logic        out_flag_ff;
   logic [7:0]  result;

   logic        wr_win, rd_win;
   logic [15:0] wr_off, rd_off;
   logic        mem_we;
   logic [IDX_W-1:0] mem_waddr;
   logic [7:0]  mem_wdata;
   func_type    func;

   assign func   = func_type'(req_func);
   assign wr_win = ({1'b0, wr_addr_ff} >= WIN_LO) && ({1'b0, wr_addr_ff} < WIN_HI);
   assign rd_win = ({1'b0, rd_addr_ff} >= WIN_LO) && ({1'b0, rd_addr_ff} < WIN_HI);
   assign wr_off = wr_addr_ff - BASE16;
   assign rd_off = rd_addr_ff - BASE16;

   // Identification entries are served from the CSR values until the bus
   // overwrites them; the memory itself only ever holds bus data or zero.
   always_comb begin
      rd_ovr     = 1'b0;
      rd_ovr_val = id_cfg.ident_high;
      if (rd_addr_ff == ID_HIGH_ADDR) begin
         rd_ovr     = id_ovr_ff[0];
         rd_ovr_val = id_cfg.ident_high;
      end else if (rd_addr_ff == ID_LOW_ADDR) begin
         rd_ovr     = id_ovr_ff[1];
         rd_ovr_val = id_cfg.ident_low;
      end else if (rd_addr_ff == DISC_ADDR) begin
         rd_ovr     = id_ovr_ff[2];
         rd_ovr_val = id_cfg.discriminator;
      end
   end

   always_comb begin
      wr_addr_in = wr_addr_ff;
      rd_addr_in = rd_addr_ff;
      seen_in    = seen_ff;
      id_ovr_in  = id_ovr_ff | id_cfg.we;
      mem_we     = 1'b0;
      mem_waddr  = wr_off[IDX_W-1:0];
      mem_wdata  = req_byte;
      if (cmd.clr_en) begin
         mem_we    = 1'b1;
         mem_waddr = clr_idx_ff;
         mem_wdata = 8'h00;
      end else if (cmd.accept) begin
         unique case (func)
            FUNC_START_WRITE: seen_in = 2'd0;
            FUNC_START_READ:  rd_addr_in = wr_addr_ff;
            FUNC_WRITE_BYTE: begin
               if (seen_ff == 2'd0) begin
                  wr_addr_in = {req_byte, wr_addr_ff[7:0]};
                  seen_in    = 2'd1;
               end else if (seen_ff == 2'd1) begin
                  wr_addr_in = {wr_addr_ff[15:8], req_byte};
                  seen_in    = ADDR_BYTES_FULL;
               end else begin
                  mem_we     = wr_win;
                  wr_addr_in = wr_addr_ff + 16'd1;
                  if (wr_win && wr_addr_ff == ID_HIGH_ADDR) id_ovr_in[0] = 1'b0;
                  if (wr_win && wr_addr_ff == ID_LOW_ADDR)  id_ovr_in[1] = 1'b0;
                  if (wr_win && wr_addr_ff == DISC_ADDR)    id_ovr_in[2] = 1'b0;
               end
            end
            FUNC_READ_BYTE:   rd_addr_in = rd_addr_ff + 16'd1;
            default:          ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_ff[mem_waddr] <= mem_wdata;
      end
      if (cmd.accept) begin
         rd_data_ff    <= store_ff[rd_off[IDX_W-1:0]];
         is_read_ff    <= (func == FUNC_READ_BYTE);
         rd_win_ff     <= rd_win;
         rd_ovr_ff     <= rd_ovr;
         rd_ovr_val_ff <= rd_ovr_val;
      end
   end

   assign result = !is_read_ff ? 8'h00 :
                   !rd_win_ff  ? OUT_OF_WINDOW :
                   rd_ovr_ff   ? rd_ovr_val_ff : rd_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_addr_ff   <= '0;
         rd_addr_ff   <= '0;
         seen_ff      <= '0;
         clr_idx_ff   <= '0;
         id_ovr_ff    <= '1;
         out_valid_ff <= 1'b0;
      end else begin
         wr_addr_ff <= wr_addr_in;
         rd_addr_ff <= rd_addr_in;
         seen_ff    <= seen_in;
         id_ovr_ff  <= id_ovr_in;
         if (cmd.clr_en) begin
            clr_idx_ff <= clr_idx_ff + 1'b1;
         end
         if (cmd.load) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         out_byte_ff <= result;
         out_flag_ff <= is_read_ff;
      end
   end

   assign status.clr_last = (clr_idx_ff == LAST_IDX);
   assign status.out_free = !out_valid_ff || rsp_tready;
   assign rsp_tvalid      = out_valid_ff;
   assign rsp_byte        = out_byte_ff;
   assign rsp_flag        = out_flag_ff;

endmodule

// ----- src/i2c_target_register_bank_16bit_addr.sv -----
`timescale 1ns / 1ps
// Register bank behind an I2C target, 16-bit big-endian register address,
// 8-bit data. Each req transaction is one bus event (req_tuser) and, for a
// write byte, the byte itself (req_tdata). Every event gives exactly one rsp
// transaction: the read byte in rsp_tdata with rsp_tuser high for a read
// byte event, zeros with rsp_tuser low for anything else.
// Events are taken one at a time, in the idle state, with req_tready high.
// Taking an event does the address update, the memory write and the
// synchronous memory read; the exec state then selects the result into the
// output register, waiting while that register is full and not draining, and
// returns to idle. rsp_tvalid is the output register's valid flag.
// After reset all WINDOW_SIZE entries (4096 by default) of the memory are
// swept to zero, one entry per cycle; req_tready stays low until the sweep
// ends. The identification registers reset to zero and can be written at
// any time over the csr port.
// A stalled rsp side holds the result in the output register; one further
// event is taken and computed, then req_tready stays low until it drains.
`include "assert_macros.svh"

module i2c_target_register_bank_16bit_addr
   import i2crb_pkg::*;
#(
   parameter int WINDOW_BASE = 12288,
   parameter int WINDOW_SIZE = 4096
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] wr_byte
   input  logic [2:0]  req_tuser,   // [2:0] func
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] rd_byte
   output logic        rsp_tuser,   // [0] rd_valid
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [7:0] ident_high_ff, ident_low_ff, disc_ff;
   logic       csr_we;
   logic [1:0] csr_idx;
   id_cfg_type    id_cfg;
   ctl_cmd_type   cmd;
   dp_status_type status;

   assign csr_pready = 1'b1;
   assign csr_we     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = csr_paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         ident_high_ff <= '0;
         ident_low_ff  <= '0;
         disc_ff       <= '0;
      end else if (csr_we) begin
         if (csr_idx == REG_IDENT_HIGH)    ident_high_ff <= csr_pwdata[7:0];
         if (csr_idx == REG_IDENT_LOW)     ident_low_ff  <= csr_pwdata[7:0];
         if (csr_idx == REG_DISCRIMINATOR) disc_ff       <= csr_pwdata[7:0];
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_IDENT_HIGH:    csr_prdata = {24'd0, ident_high_ff};
         REG_IDENT_LOW:     csr_prdata = {24'd0, ident_low_ff};
         REG_DISCRIMINATOR: csr_prdata = {24'd0, disc_ff};
         default:           csr_prdata = 32'd0;
      endcase
   end

   assign id_cfg.we[0]         = csr_we && (csr_idx == REG_IDENT_HIGH);
   assign id_cfg.we[1]         = csr_we && (csr_idx == REG_IDENT_LOW);
   assign id_cfg.we[2]         = csr_we && (csr_idx == REG_DISCRIMINATOR);
   assign id_cfg.ident_high    = ident_high_ff;
   assign id_cfg.ident_low     = ident_low_ff;
   assign id_cfg.discriminator = disc_ff;

   i2crb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   i2crb_dp #(
      .WINDOW_BASE (WINDOW_BASE),
      .WINDOW_SIZE (WINDOW_SIZE)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .id_cfg     (id_cfg),
      .req_func   (req_tuser),
      .req_byte   (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_byte   (rsp_tdata),
      .rsp_flag   (rsp_tuser)
   );

   `ASSERT_NEVER(a_no_accept_in_clear, clock, reset, cmd.clr_en && req_tready, "accept during memory clear")
   `ASSERT_PROP(a_one_at_a_time, clock, reset, (req_tvalid && req_tready) |=> !req_tready, "back-to-back accept")
   `ASSERT_PROP(a_result_follows, clock, reset, (req_tvalid && req_tready) |=> ##1 (rsp_tvalid || !req_tready), "result not produced")
   `ASSERT_PROP(a_non_read_zero, clock, reset, (rsp_tvalid && !rsp_tuser) |-> (rsp_tdata == 8'h00), "non-read result carries data")

endmodule

// ----- tb/reg_bank_checker.sv -----
`timescale 1ns / 1ps

module reg_bank_checker
   import i2crb_pkg::*;
#(
   parameter int WINDOW_BASE = 12288,
   parameter int WINDOW_SIZE = 4096
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic [2:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [7:0]  rsp_tdata,
   input  logic        rsp_tuser,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   input  logic [31:0] csr_prdata,
   input  logic        csr_pready,
   output int          mismatches,
   output int          outstanding
);

   typedef struct packed {
      logic [7:0] rd_byte;
      logic       rd_valid;
   } read_reply_type;

   logic [7:0]  bank_mem [WINDOW_SIZE];
   logic [7:0]  id_values [3];
   logic [15:0] write_ptr;
   logic [15:0] read_ptr;
   logic [1:0]  addr_count;
   read_reply_type replies_due [$];
   int          err_count = 0;

   function automatic bit in_window(logic [15:0] a);
      return int'(a) >= WINDOW_BASE && int'(a) < WINDOW_BASE + WINDOW_SIZE;
   endfunction

   function automatic void bank_put(logic [15:0] a, logic [7:0] v);
      if (in_window(a)) bank_mem[int'(a) - WINDOW_BASE] = v;
   endfunction

   function automatic logic [7:0] bank_get(logic [15:0] a);
      if (in_window(a)) return bank_mem[int'(a) - WINDOW_BASE];
      return OUT_OF_WINDOW;
   endfunction

   function automatic logic [15:0] id_address(logic [1:0] idx);
      case (idx)
         REG_IDENT_HIGH: return ID_HIGH_ADDR;
         REG_IDENT_LOW:  return ID_LOW_ADDR;
         default:        return DISC_ADDR;
      endcase
   endfunction

   // Applies one bus event to the tracked bank state and returns the reply it must produce.
   function automatic read_reply_type predict_event(logic [2:0] func, logic [7:0] data);
      read_reply_type r;
      r = '0;
      case (func)
         FUNC_START_WRITE: addr_count = 2'd0;
         FUNC_START_READ:  read_ptr = write_ptr;
         FUNC_WRITE_BYTE: begin
            if (addr_count == 2'd0) begin
               write_ptr[15:8] = data;
               addr_count = 2'd1;
            end else if (addr_count == 2'd1) begin
               write_ptr[7:0] = data;
               addr_count = ADDR_BYTES_FULL;
            end else begin
               bank_put(write_ptr, data);
               write_ptr = write_ptr + 16'd1;
            end
         end
         FUNC_READ_BYTE: begin
            r.rd_byte = bank_get(read_ptr);
            r.rd_valid = 1'b1;
            read_ptr = read_ptr + 16'd1;
         end
         default: ;
      endcase
      return r;
   endfunction

   task automatic flag(string what, logic [31:0] want, logic [31:0] got);
      err_count++;
      if (err_count <= 10)
         $display("%0t: %s mismatch: expected %0h, got %0h", $time, what, want, got);
   endtask

   always @(posedge clock) begin : track
      read_reply_type want;
      logic [1:0]  reg_idx;
      if (reset) begin
         foreach (bank_mem[i]) bank_mem[i] = 8'h00;
         foreach (id_values[i]) begin
            id_values[i] = 8'h00;
            bank_put(id_address(2'(i)), 8'h00);
         end
         write_ptr = '0;
         read_ptr = '0;
         addr_count = '0;
         replies_due.delete();
      end else begin
         // Results leave in order, so each one answers the oldest open prediction.
         if (rsp_tvalid && rsp_tready) begin
            if (replies_due.size() == 0) begin
               flag("unexpected result, rd_byte", 32'd0, 32'(rsp_tdata));
            end else begin
               want = replies_due.pop_front();
               if (rsp_tdata !== want.rd_byte)
                  flag("rd_byte", 32'(want.rd_byte), 32'(rsp_tdata));
               if (rsp_tuser !== want.rd_valid)
                  flag("rd_valid", 32'(want.rd_valid), 32'(rsp_tuser));
            end
         end
         if (req_tvalid && req_tready)
            replies_due.push_back(predict_event(req_tuser, req_tdata));
         reg_idx = csr_paddr[3:2];
         if (csr_psel && csr_penable && csr_pready && csr_paddr[1:0] == 2'b00 &&
             reg_idx <= REG_DISCRIMINATOR) begin
            if (csr_pwrite) begin
               id_values[reg_idx] = csr_pwdata[7:0];
               bank_put(id_address(reg_idx), csr_pwdata[7:0]);
            end else if (csr_prdata !== {24'h0, id_values[reg_idx]}) begin
               flag("csr read", {24'h0, id_values[reg_idx]}, csr_prdata);
            end
         end
      end
      mismatches <= err_count;
      outstanding <= replies_due.size();
   end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

module tb;
   import i2crb_pkg::*;

   localparam int WINDOW_BASE = 12288;
   localparam int WINDOW_SIZE = 4096;
   // Covers the clearing sweep after reset with a wide margin.
   localparam int STALL_LIMIT = 20000;
   localparam int RANDOM_PHASES = 6;
   localparam int EVENTS_PER_PHASE = 300;
   localparam logic [1:0] REG_UNUSED = 2'd3;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;   // [7:0] wr_byte
   logic [2:0]  req_tuser;   // [2:0] func
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;   // [7:0] rd_byte
   logic        rsp_tuser;   // [0] rd_valid
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [3:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   int mismatches;
   int outstanding;
   int req_gap_max = 15;
   int rsp_stall_max = 15;
   int events_sent = 0;
   int quiet_cycles = 0;

   i2c_target_register_bank_16bit_addr #(
      .WINDOW_BASE (WINDOW_BASE),
      .WINDOW_SIZE (WINDOW_SIZE)
   ) u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   reg_bank_checker #(
      .WINDOW_BASE (WINDOW_BASE),
      .WINDOW_SIZE (WINDOW_SIZE)
   ) u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_psel && csr_penable))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == STALL_LIMIT) begin
         $display("Watchdog: no transaction for %0d cycles", STALL_LIMIT);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Result side: a fresh random stall before each transaction.
   initial begin : rsp_side
      int stall;
      rsp_tready = 1'b0;
      while (reset !== 1'b0) @(negedge clock);
      forever begin
         stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, rsp_stall_max);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         @(negedge clock);
      end
   end

   // Leaves req_tvalid high after the transaction; the next call with a gap, or wait_idle, lowers it.
   task automatic send_event(logic [2:0] func, logic [7:0] data);
      int gap;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, req_gap_max);
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= func;
      req_tdata <= data;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (func <= FUNC_READ_BYTE) events_sent++;
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic csr_access(logic write, logic [1:0] idx, logic [7:0] value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= write;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= {24'h0, value};
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic load_ids(logic [7:0] high, logic [7:0] low, logic [7:0] disc);
      wait_idle();
      csr_access(1'b1, REG_IDENT_HIGH, high);
      csr_access(1'b1, REG_IDENT_LOW, low);
      csr_access(1'b1, REG_DISCRIMINATOR, disc);
      csr_access(1'b0, REG_IDENT_HIGH, 8'h00);
      csr_access(1'b0, REG_IDENT_LOW, 8'h00);
      csr_access(1'b0, REG_DISCRIMINATOR, 8'h00);
   endtask

   task automatic set_address(logic [15:0] a);
      send_event(FUNC_START_WRITE, 8'($urandom));
      send_event(FUNC_WRITE_BYTE, a[15:8]);
      send_event(FUNC_WRITE_BYTE, a[7:0]);
   endtask

   task automatic run_directed();
      logic [15:0] top;
      top = 16'(WINDOW_BASE + WINDOW_SIZE - 1);
      // Identification entries as they come out of reset.
      set_address(ID_HIGH_ADDR);
      send_event(FUNC_START_READ, 8'hFF);
      repeat (3) send_event(FUNC_READ_BYTE, 8'h00);
      // Last entry of the window, then a byte that falls just past it.
      set_address(top);
      send_event(FUNC_WRITE_BYTE, 8'h00);
      send_event(FUNC_WRITE_BYTE, 8'hFF);
      // Read across the top of the address space.
      set_address(16'hFFFF);
      send_event(FUNC_START_READ, 8'h00);
      repeat (2) send_event(FUNC_READ_BYTE, 8'hFF);
      // Only the high byte arrives; the low byte stays 0xFF from before.
      send_event(FUNC_START_WRITE, 8'h00);
      send_event(FUNC_WRITE_BYTE, top[15:8]);
      send_event(FUNC_START_READ, 8'h00);
      repeat (2) send_event(FUNC_READ_BYTE, 8'h00);
      for (int k = int'(FUNC_OTHER); k < 2 ** $bits(func_type); k++)
         send_event(3'(k), 8'($urandom));
   endtask

   function automatic logic [15:0] pick_address();
      logic [15:0] edge_base;
      edge_base = $urandom_range(0, 1) ? 16'(WINDOW_BASE) : 16'(WINDOW_BASE + WINDOW_SIZE);
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: return ID_HIGH_ADDR - 16'd8 + 16'($urandom_range(0, 31));
         5, 6:          return 16'(WINDOW_BASE + $urandom_range(0, WINDOW_SIZE - 1));
         7:             return edge_base - 16'd8 + 16'($urandom_range(0, 15));
         8:             return 16'hFFF8 + 16'($urandom_range(0, 7));
         default:       return 16'($urandom);
      endcase
   endfunction

   // Mostly complete write and read transfers to a random address, some noise.
   task automatic run_traffic(int quota);
      int first;
      int burst;
      int pick;
      first = events_sent;
      while (events_sent - first < quota) begin
         burst = $urandom_range(1, 8);
         pick = $urandom_range(0, 19);
         if (pick < 9) begin
            set_address(pick_address());
            repeat (burst) send_event(FUNC_WRITE_BYTE, 8'($urandom));
         end else if (pick < 17) begin
            set_address(pick_address());
            send_event(FUNC_START_READ, 8'($urandom));
            repeat (burst) send_event(FUNC_READ_BYTE, 8'($urandom));
         end else if (pick < 18) begin
            send_event(FUNC_START_READ, 8'($urandom));
            repeat (burst) send_event(FUNC_READ_BYTE, 8'($urandom));
         end else begin
            repeat (burst) send_event(3'($urandom_range(0, 7)), 8'($urandom));
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = 8'h00;
      req_tuser = FUNC_OTHER;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      run_directed();
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         if (phase == 0) begin
            load_ids(8'hFF, 8'hFF, 8'hFF);
            csr_access(1'b1, REG_UNUSED, 8'h5A);
         end else if (phase == 1) begin
            load_ids(8'h00, 8'h00, 8'h00);
         end else begin
            load_ids(8'($urandom), 8'($urandom), 8'($urandom));
         end
         req_gap_max = (phase % 2 == 0) ? 15 : 0;
         rsp_stall_max = (phase % 4 < 2) ? 15 : 0;
         run_traffic(EVENTS_PER_PHASE);
      end
      wait_idle();

      if (mismatches == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
+incdir+src
src/i2crb_pkg.sv
src/i2crb_ctrl.sv
src/i2crb_dp.sv
src/i2c_target_register_bank_16bit_addr.sv
tb/reg_bank_checker.sv
tb/tb.sv
